// File: rtl/core/hsvrgb_pkg.sv
// shared types and constants for the hsv to rgb converter
// no dependencies
`default_nettype none

package hsvrgb_pkg;

    localparam int HUE_W = 15;
    localparam int LVL_W = 13;
    localparam int REM_W = 12;

    localparam logic [HUE_W-1:0] SECTOR_UNITS = 15'd3840;
    localparam logic [HUE_W-1:0] TURN_UNITS   = 15'd23040;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

    typedef struct packed {
        logic    vld;
        t_sector sector;
    } t_ctrl;

endpackage

`default_nettype wire

// File: rtl/core/hsv_to_rgb_converter.sv
// hsv to rgb converter top level: five register stages, one pixel per cycle while the output is not held
// path: an accepted request passes the prep, scale stage a, b and c, and mux registers to the output
// throughput: one request per cycle; a held result freezes every stage in step
// reset: synchronous active low, clears all stage valid bits, input stalled meanwhile
// depends on hsvrgb_pkg, hsvrgb_prep, hsvrgb_scale, hsvrgb_mux
`default_nettype none

module hsv_to_rgb_converter
    import hsvrgb_pkg::*;
#(
    parameter int FRAC_BITS = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [HUE_W-1:0] i_hue_angle,
    input  wire logic [LVL_W-1:0] i_sat_level,
    input  wire logic [LVL_W-1:0] i_val_level,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic [LVL_W-1:0]      o_red_out,
    output logic [LVL_W-1:0]      o_green_out,
    output logic [LVL_W-1:0]      o_blue_out
);

    localparam int W = FRAC_BITS + 1;

    logic             en;
    logic             in_acc;
    t_ctrl            prep_ctrl;
    t_ctrl            scale_ctrl;
    logic [REM_W-1:0] prep_rem;
    logic [W-1:0]     prep_sat;
    logic [W-1:0]     prep_val;
    logic [W-1:0]     sc_p;
    logic [W-1:0]     sc_q;
    logic [W-1:0]     sc_t;
    logic [W-1:0]     sc_v;

    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !i_rst_n || !en;
    assign in_acc     = i_in_valid && !o_in_stall;

    hsvrgb_prep #(
        .FRAC_BITS(FRAC_BITS)
    ) u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_req_vld   (in_acc),
        .i_hue_angle (i_hue_angle),
        .i_sat_level (i_sat_level),
        .i_val_level (i_val_level),
        .o_ctrl      (prep_ctrl),
        .o_rem       (prep_rem),
        .o_sat       (prep_sat),
        .o_val       (prep_val)
    );

    hsvrgb_scale #(
        .FRAC_BITS(FRAC_BITS)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctrl  (prep_ctrl),
        .i_rem   (prep_rem),
        .i_sat   (prep_sat),
        .i_val   (prep_val),
        .o_ctrl  (scale_ctrl),
        .o_p     (sc_p),
        .o_q     (sc_q),
        .o_t     (sc_t),
        .o_v     (sc_v)
    );

    hsvrgb_mux #(
        .FRAC_BITS(FRAC_BITS)
    ) u_mux (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctrl  (scale_ctrl),
        .i_p     (sc_p),
        .i_q     (sc_q),
        .i_t     (sc_t),
        .i_v     (sc_v),
        .o_vld   (o_out_valid),
        .o_red   (o_red_out),
        .o_green (o_green_out),
        .o_blue  (o_blue_out)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(en, 1) && $past(en, 2) && $past(en, 3) && $past(en, 4) && $past(en, 5))
        |-> (o_out_valid == $past(in_acc, 5)))
        else $error("result valid does not follow request after five cycles");

endmodule

`default_nettype wire

// File: rtl/core/hsvrgb_prep.sv
// first stage: hue wrap, sector split and remainder, level clamping
// depends on hsvrgb_pkg
`default_nettype none

module hsvrgb_prep
    import hsvrgb_pkg::*;
#(
    parameter int FRAC_BITS = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_req_vld,
    input  wire logic [HUE_W-1:0] i_hue_angle,
    input  wire logic [LVL_W-1:0] i_sat_level,
    input  wire logic [LVL_W-1:0] i_val_level,
    output t_ctrl                 o_ctrl,
    output logic [REM_W-1:0]      o_rem,
    output logic [FRAC_BITS:0]    o_sat,
    output logic [FRAC_BITS:0]    o_val
);

    localparam int W  = FRAC_BITS + 1;
    localparam int XW = (W > LVL_W) ? W : LVL_W;
    localparam logic [XW-1:0] ONE_X = XW'(1) << FRAC_BITS;
    localparam logic [HUE_W-1:0] B1 = HUE_W'(SECTOR_UNITS * 1);
    localparam logic [HUE_W-1:0] B2 = HUE_W'(SECTOR_UNITS * 2);
    localparam logic [HUE_W-1:0] B3 = HUE_W'(SECTOR_UNITS * 3);
    localparam logic [HUE_W-1:0] B4 = HUE_W'(SECTOR_UNITS * 4);
    localparam logic [HUE_W-1:0] B5 = HUE_W'(SECTOR_UNITS * 5);

    logic             r_vld;
    t_sector          r_sec;
    logic [REM_W-1:0] r_rem;
    logic [W-1:0]     r_sat;
    logic [W-1:0]     r_val;

    logic [HUE_W-1:0] hue;
    logic [HUE_W-1:0] base;
    t_sector          n_sec;
    logic [REM_W-1:0] n_rem;
    logic [XW-1:0]    sat_x;
    logic [XW-1:0]    val_x;
    logic [W-1:0]     n_sat;
    logic [W-1:0]     n_val;

    always_comb begin
        hue = (i_hue_angle >= TURN_UNITS) ? (i_hue_angle - TURN_UNITS) : i_hue_angle;
        if (hue >= B5) begin
            n_sec = SEC_5;
            base  = B5;
        end else if (hue >= B4) begin
            n_sec = SEC_4;
            base  = B4;
        end else if (hue >= B3) begin
            n_sec = SEC_3;
            base  = B3;
        end else if (hue >= B2) begin
            n_sec = SEC_2;
            base  = B2;
        end else if (hue >= B1) begin
            n_sec = SEC_1;
            base  = B1;
        end else begin
            n_sec = SEC_0;
            base  = '0;
        end
        n_rem = REM_W'(hue - base);
        sat_x = XW'(i_sat_level);
        val_x = XW'(i_val_level);
        n_sat = W'((sat_x > ONE_X) ? ONE_X : sat_x);
        n_val = W'((val_x > ONE_X) ? ONE_X : val_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_req_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sec <= n_sec;
            r_rem <= n_rem;
            r_sat <= n_sat;
            r_val <= n_val;
        end
    end

    assign o_ctrl = '{vld: r_vld, sector: r_sec};
    assign o_rem  = r_rem;
    assign o_sat  = r_sat;
    assign o_val  = r_val;

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> (HUE_W'(r_rem) < SECTOR_UNITS))
        else $error("remainder beyond one sector");

endmodule

`default_nettype wire

// File: rtl/core/hsvrgb_scale.sv
// stages two to four: hue fraction, then p, q and t products
// depends on hsvrgb_pkg
`default_nettype none

module hsvrgb_scale
    import hsvrgb_pkg::*;
#(
    parameter int FRAC_BITS = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire t_ctrl            i_ctrl,
    input  wire logic [REM_W-1:0] i_rem,
    input  wire logic [FRAC_BITS:0] i_sat,
    input  wire logic [FRAC_BITS:0] i_val,
    output t_ctrl                 o_ctrl,
    output logic [FRAC_BITS:0]    o_p,
    output logic [FRAC_BITS:0]    o_q,
    output logic [FRAC_BITS:0]    o_t,
    output logic [FRAC_BITS:0]    o_v
);

    localparam int W  = FRAC_BITS + 1;
    localparam int YW = REM_W + FRAC_BITS - 8;
    localparam int MW = FRAC_BITS + 5;
    localparam int PW = YW + MW;
    localparam int SW = W + FRAC_BITS;
    localparam longint unsigned RECIP_L = ((64'd1 << (FRAC_BITS + 8)) + 64'd14) / 15;
    localparam logic [MW-1:0] RECIP = MW'(RECIP_L);
    localparam logic [W-1:0]  ONE   = W'(1) << FRAC_BITS;

    // stage a: fraction and p
    logic                 r_a_vld;
    t_sector              r_a_sec;
    logic [FRAC_BITS-1:0] r_a_f;
    logic [W-1:0]         r_a_p;
    logic [W-1:0]         r_a_s;
    logic [W-1:0]         r_a_v;

    logic [YW-1:0]        y;
    logic [PW-1:0]        f_prod;
    logic [2*W-1:0]       p_prod;
    logic [FRAC_BITS-1:0] n_a_f;
    logic [W-1:0]         n_a_p;

    always_comb begin
        y      = YW'(i_rem) << (FRAC_BITS - 8);
        f_prod = PW'(y) * PW'(RECIP);
        n_a_f  = FRAC_BITS'(f_prod >> (FRAC_BITS + 8));
        p_prod = (2*W)'(i_val) * (2*W)'(ONE - i_sat);
        n_a_p  = W'(p_prod >> FRAC_BITS);
    end

    // stage b: s*f and s*(1-f)
    logic         r_b_vld;
    t_sector      r_b_sec;
    logic [W-1:0] r_b_sf;
    logic [W-1:0] r_b_sg;
    logic [W-1:0] r_b_p;
    logic [W-1:0] r_b_v;

    logic [SW-1:0] sf_prod;
    logic [SW-1:0] sg_prod;
    logic [W-1:0]  n_b_sf;
    logic [W-1:0]  n_b_sg;

    always_comb begin
        sf_prod = SW'(r_a_s) * SW'(r_a_f);
        sg_prod = SW'(r_a_s) * SW'(ONE - W'(r_a_f));
        n_b_sf  = W'(sf_prod >> FRAC_BITS);
        n_b_sg  = W'(sg_prod >> FRAC_BITS);
    end

    // stage c: q and t
    logic         r_c_vld;
    t_sector      r_c_sec;
    logic [W-1:0] r_c_p;
    logic [W-1:0] r_c_q;
    logic [W-1:0] r_c_t;
    logic [W-1:0] r_c_v;

    logic [2*W-1:0] q_prod;
    logic [2*W-1:0] t_prod;
    logic [W-1:0]   n_c_q;
    logic [W-1:0]   n_c_t;

    always_comb begin
        q_prod = (2*W)'(r_b_v) * (2*W)'(ONE - r_b_sf);
        t_prod = (2*W)'(r_b_v) * (2*W)'(ONE - r_b_sg);
        n_c_q  = W'(q_prod >> FRAC_BITS);
        n_c_t  = W'(t_prod >> FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_ctrl.vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_sec <= i_ctrl.sector;
            r_a_f   <= n_a_f;
            r_a_p   <= n_a_p;
            r_a_s   <= i_sat;
            r_a_v   <= i_val;
            r_b_sec <= r_a_sec;
            r_b_sf  <= n_b_sf;
            r_b_sg  <= n_b_sg;
            r_b_p   <= r_a_p;
            r_b_v   <= r_a_v;
            r_c_sec <= r_b_sec;
            r_c_p   <= r_b_p;
            r_c_q   <= n_c_q;
            r_c_t   <= n_c_t;
            r_c_v   <= r_b_v;
        end
    end

    assign o_ctrl = '{vld: r_c_vld, sector: r_c_sec};
    assign o_p    = r_c_p;
    assign o_q    = r_c_q;
    assign o_t    = r_c_t;
    assign o_v    = r_c_v;

    a_p_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_vld |-> (r_c_p <= r_c_q && r_c_p <= r_c_t))
        else $error("p above q or t");

    a_v_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_vld |-> (r_c_q <= r_c_v && r_c_t <= r_c_v && r_c_v <= ONE))
        else $error("q or t above value");

endmodule

`default_nettype wire

// File: rtl/core/hsvrgb_mux.sv
// last stage: sector permutation into the output register
// depends on hsvrgb_pkg
`default_nettype none

module hsvrgb_mux
    import hsvrgb_pkg::*;
#(
    parameter int FRAC_BITS = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire t_ctrl            i_ctrl,
    input  wire logic [FRAC_BITS:0] i_p,
    input  wire logic [FRAC_BITS:0] i_q,
    input  wire logic [FRAC_BITS:0] i_t,
    input  wire logic [FRAC_BITS:0] i_v,
    output logic                  o_vld,
    output logic [LVL_W-1:0]      o_red,
    output logic [LVL_W-1:0]      o_green,
    output logic [LVL_W-1:0]      o_blue
);

    localparam int W  = FRAC_BITS + 1;
    localparam int XW = (W > LVL_W) ? W : LVL_W;

    logic             r_vld;
    logic [LVL_W-1:0] r_red;
    logic [LVL_W-1:0] r_green;
    logic [LVL_W-1:0] r_blue;

    logic [W-1:0]  sel_r;
    logic [W-1:0]  sel_g;
    logic [W-1:0]  sel_b;
    logic [XW-1:0] ext_r;
    logic [XW-1:0] ext_g;
    logic [XW-1:0] ext_b;

    always_comb begin
        case (i_ctrl.sector)
            SEC_0: begin
                sel_r = i_v;
                sel_g = i_t;
                sel_b = i_p;
            end
            SEC_1: begin
                sel_r = i_q;
                sel_g = i_v;
                sel_b = i_p;
            end
            SEC_2: begin
                sel_r = i_p;
                sel_g = i_v;
                sel_b = i_t;
            end
            SEC_3: begin
                sel_r = i_p;
                sel_g = i_q;
                sel_b = i_v;
            end
            SEC_4: begin
                sel_r = i_t;
                sel_g = i_p;
                sel_b = i_v;
            end
            default: begin
                sel_r = i_v;
                sel_g = i_p;
                sel_b = i_q;
            end
        endcase
        ext_r = XW'(sel_r);
        ext_g = XW'(sel_g);
        ext_b = XW'(sel_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_ctrl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red   <= ext_r[LVL_W-1:0];
            r_green <= ext_g[LVL_W-1:0];
            r_blue  <= ext_b[LVL_W-1:0];
        end
    end

    assign o_vld   = r_vld;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

`default_nettype wire
